// ----- sv/qcs_pkg.sv -----
// Shared widths, constants, pipeline payload types and output conversion
// for the quartic cosine/sine shaper. No dependencies.
package qcs_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int RESULT_WIDTH = 18;
    localparam int GAIN_WIDTH   = 16;

    // Internal fraction bits of the polynomial path.
    localparam int IFRAC        = 24;
    // round(2/pi * 2^30)
    localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 16'd4096;
    // ceil(2^33 / 3): floor(x/3) = (x * RECIP3) >> 33 for x < 2^32
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    // Square root chain: 60-bit radicand, two bits per cell.
    localparam int RAD_WIDTH  = 60;
    localparam int ROOT_WIDTH = RAD_WIDTH / 2;
    localparam int NUM_CELLS  = ROOT_WIDTH;
    localparam int REM_WIDTH  = ROOT_WIDTH + 2;

    // Register map of the configuration port.
    localparam logic [1:0] REG_QUAD_GAIN    = 2'd0;
    localparam logic [1:0] REG_QUARTIC_GAIN = 2'd1;

    // Sideband that rides along the root chain.
    typedef struct packed {
        logic signed [31:0] cosine;  // Q.24
        logic               ang_neg;
        logic               ang_zero;
        logic               d_neg;
        logic               d_zero;
    } t_side;

    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
        logic [RAD_WIDTH-1:0]  rad;
        t_side                 side;
    } t_sq;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] value;
        logic                    sat;
    } t_out;

    localparam int OUT_FRAC = RESULT_WIDTH - 4;
    localparam int OUT_LSH  = (OUT_FRAC >= IFRAC) ? OUT_FRAC - IFRAC : 0;
    localparam int OUT_RSH  = (OUT_FRAC >= IFRAC) ? 0 : IFRAC - OUT_FRAC;

    // Q.24 to output format: round half away from zero, then clamp.
    function automatic t_out to_out(input logic signed [31:0] v);
        logic        neg;
        logic [63:0] m;
        logic [63:0] lim;
        t_out        res;
        neg = v[31];
        m   = neg ? 64'(-{{32{v[31]}}, v}) : 64'({32'd0, v});
        m   = ((m << OUT_LSH) + ((64'd1 << OUT_RSH) >> 1)) >> OUT_RSH;
        lim = 64'd1 << (RESULT_WIDTH - 1);
        res.sat = 1'b0;
        if (neg) begin
            if (m > lim) begin
                m       = lim;
                res.sat = 1'b1;
            end
        end else if (m > lim - 64'd1) begin
            m       = lim - 64'd1;
            res.sat = 1'b1;
        end
        res.value = neg ? RESULT_WIDTH'(64'd0 - m) : RESULT_WIDTH'(m);
        return res;
    endfunction

endpackage

// ----- sv/qcs_poly.sv -----
// Front pipeline of the shaper: angle scaling, polynomial cosine and the
// radicand 1 - c^2. Depends on qcs_pkg.
module qcs_poly (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [qcs_pkg::ANGLE_WIDTH-1:0] i_angle,
    input  logic signed [qcs_pkg::GAIN_WIDTH-1:0]  i_quad_gain,
    input  logic signed [qcs_pkg::GAIN_WIDTH-1:0]  i_quartic_gain,
    output logic                                o_valid,
    output qcs_pkg::t_sq                        o_data
);
    import qcs_pkg::*;

    localparam int USH = ANGLE_WIDTH + 3;
    localparam int PW  = ANGLE_WIDTH + 31;

    logic [6:0] r_v;

    // stage payloads
    logic signed [PW-1:0] r_p1;
    logic [1:0]           r_s1, r_s2, r_s3, r_s4, r_s5, r_s6; // {neg, zero}
    logic [51:0]          r_uu;
    logic [53:0]          r_u2sq;
    logic signed [43:0]   r_pa;
    logic signed [30:0]   r_ta4, r_ta5;
    logic signed [46:0]   r_pb;
    logic [30:0]          r_x;
    logic                 r_xneg;
    logic signed [31:0]   r_c6, r_c7;
    logic signed [63:0]   r_d;
    logic [1:0]           r_s7;

    logic [PW-1:0]      p1_mag;
    logic [26:0]        u_mag;
    logic [27:0]        u2;
    logic [29:0]        u4;
    logic [43:0]        pa_mag;
    logic [30:0]        ta_mag;
    logic signed [30:0] ta;
    logic [46:0]        pb_mag;
    logic [62:0]        q_full;
    logic signed [32:0] tb;
    logic signed [32:0] c_sum;
    logic signed [63:0] cc;
    logic [63:0]        d_mag;

    always_comb begin
        p1_mag = r_p1[PW-1] ? PW'(-r_p1) : PW'(r_p1);
        u_mag  = 27'((p1_mag + (PW'(1) << (USH - 1))) >> USH);
        u2     = 28'((r_uu + 52'd8388608) >> IFRAC);
        u4     = 30'((r_u2sq + 54'd8388608) >> IFRAC);
        pa_mag = r_pa[43] ? 44'(-r_pa) : 44'(r_pa);
        ta_mag = 31'((pa_mag + 44'd4096) >> 13);
        ta     = r_pa[43] ? -$signed(ta_mag) : $signed(ta_mag);
        pb_mag = r_pb[46] ? 47'(-r_pb) : 47'(r_pb);
        q_full = 63'(({32'd0, r_x} * {31'd0, RECIP3}) >> 33);
        tb     = r_xneg ? -$signed(33'(q_full)) : $signed(33'(q_full));
        c_sum  = $signed(33'(1) << IFRAC) - 33'(r_ta5) + tb;
        cc     = r_c6 * r_c6;
        d_mag  = r_d[63] ? 64'(-r_d) : 64'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // scale angle by 2/pi
            r_p1   <= PW'(i_angle) * $signed({1'b0, TWO_OVER_PI_Q30});
            r_s1   <= {i_angle[ANGLE_WIDTH-1], i_angle == '0};
            // u^2
            r_uu   <= 52'(u_mag) * 52'(u_mag);
            r_s2   <= r_s1;
            // u^4 and quadratic term
            r_u2sq <= 54'(u2) * 54'(u2);
            r_pa   <= 44'(i_quad_gain) * $signed({16'd0, u2});
            r_s3   <= r_s2;
            // quartic term
            r_pb   <= 47'(i_quartic_gain) * $signed({17'd0, u4});
            r_ta4  <= ta;
            r_s4   <= r_s3;
            // divide by 24: round at 3*2^15 via shift, then /3
            r_x    <= 31'((pb_mag + 47'd49152) >> 15);
            r_xneg <= r_pb[46];
            r_ta5  <= r_ta4;
            r_s5   <= r_s4;
            r_c6   <= 32'(c_sum);
            r_s6   <= r_s5;
            r_d    <= (64'sd1 <<< (2 * IFRAC)) - cc;
            r_c7   <= r_c6;
            r_s7   <= r_s6;
        end
    end

    assign o_valid = r_v[6];

    always_comb begin
        o_data.rem           = '0;
        o_data.root          = '0;
        o_data.rad           = RAD_WIDTH'(d_mag);
        o_data.side.cosine   = r_c7;
        o_data.side.ang_neg  = r_s7[1];
        o_data.side.ang_zero = r_s7[0];
        o_data.side.d_neg    = r_d[63];
        o_data.side.d_zero   = (r_d == '0);
    end

endmodule

// ----- sv/qcs_cell.sv -----
// One cell of the square root chain: retires two radicand bits and one
// root bit per cycle while i_en is high. Depends on qcs_pkg.
module qcs_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  qcs_pkg::t_sq i_data,
    output logic         o_valid,
    output qcs_pkg::t_sq o_data
);
    import qcs_pkg::*;

    logic                   r_valid;
    t_sq                    r_data;
    t_sq                    n_data;
    logic [REM_WIDTH+1:0]   rem_s;
    logic [REM_WIDTH+1:0]   trial;

    always_comb begin
        rem_s  = {i_data.rem, i_data.rad[RAD_WIDTH-1 -: 2]};
        trial  = (REM_WIDTH+2)'({i_data.root, 2'b01});
        n_data = i_data;
        n_data.rad = i_data.rad << 2;
        if (rem_s >= trial) begin
            n_data.rem  = REM_WIDTH'(rem_s - trial);
            n_data.root = {i_data.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            n_data.rem  = REM_WIDTH'(rem_s);
            n_data.root = {i_data.root[ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/quartic_cos_sin_shaper.sv -----
// Top level of the quartic cosine/sine shaper: config registers, front
// pipeline, square root cell chain and output stage. Depends on qcs_pkg.

// One angle request in, one {cosine, sine, saturated} request out, a new
// angle every clock. Each angle passes the polynomial front end (multipliers
// spread over the stages), the square root chain (one root bit per cell),
// and then the rounding/clamping output register. The whole pipeline advances
// together; it holds only while a finished result sits in the output
// register and the sink stalls, and o_in_stall reports exactly that.
// Gains are Q4.12 and reset to 1.0; write them only while the pipe is empty.
// Outputs are Q4.14, rounded half away from zero and clamped; the flag is
// set when either one was clipped. Sine is zero for a zero angle or for a
// cosine of exactly plus or minus one.
module quartic_cos_sin_shaper (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // angle requests
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [qcs_pkg::ANGLE_WIDTH-1:0]  i_angle,
    // result requests
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [qcs_pkg::RESULT_WIDTH-1:0] o_cosine,
    output logic signed [qcs_pkg::RESULT_WIDTH-1:0] o_sine,
    output logic                                    o_saturated,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [1:0]                              i_cfg_index,
    input  logic [qcs_pkg::GAIN_WIDTH-1:0]          i_cfg_data
);
    import qcs_pkg::*;

    logic signed [GAIN_WIDTH-1:0] r_quad_gain;
    logic signed [GAIN_WIDTH-1:0] r_quartic_gain;

    logic en;
    logic chain_valid [NUM_CELLS+1];
    t_sq  chain_data  [NUM_CELLS+1];

    logic                       r_out_valid;
    logic [RESULT_WIDTH-1:0]    r_cosine;
    logic [RESULT_WIDTH-1:0]    r_sine;
    logic                       r_saturated;

    t_sq                 last;
    logic signed [31:0]  sine_q24;
    t_out                cos_o;
    t_out                sin_o;

    // advance unless a result is waiting on a stalled sink
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_gain    <= GAIN_ONE;
            r_quartic_gain <= GAIN_ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_QUAD_GAIN:    r_quad_gain    <= i_cfg_data;
                REG_QUARTIC_GAIN: r_quartic_gain <= i_cfg_data;
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    qcs_poly u_poly (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_angle        (i_angle),
        .i_quad_gain    (r_quad_gain),
        .i_quartic_gain (r_quartic_gain),
        .o_valid        (chain_valid[0]),
        .o_data         (chain_data[0])
    );

    // square root chain, one root bit per cell, MSB first
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        qcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // sign the root: negative when exactly one of angle and 1-c^2 is negative
    always_comb begin
        last = chain_data[NUM_CELLS];
        if (last.side.ang_zero || last.side.d_zero) begin
            sine_q24 = '0;
        end else if (last.side.ang_neg != last.side.d_neg) begin
            sine_q24 = -$signed({2'b00, last.root});
        end else begin
            sine_q24 = $signed({2'b00, last.root});
        end
        cos_o = to_out(last.side.cosine);
        sin_o = to_out(sine_q24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cosine    <= cos_o.value;
            r_sine      <= sin_o.value;
            r_saturated <= cos_o.sat | sin_o.sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cosine    = $signed(r_cosine);
    assign o_sine      = $signed(r_sine);
    assign o_saturated = r_saturated;

endmodule

// ----- tb/quartic_cos_sin_shaper_tb.sv -----
// Self-checking testbench for the quartic cosine/sine shaper: drives angle
// requests and gain writes, predicts each result, compares field by field.
// Depends on qcs_pkg and the quartic_cos_sin_shaper top level.
`timescale 1ns / 1ps

module quartic_cos_sin_shaper_tb;
    import qcs_pkg::*;

    localparam int PIPE_DEPTH  = 38;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [RESULT_WIDTH-1:0] cosine;
        logic signed [RESULT_WIDTH-1:0] sine;
        logic                           saturated;
    } t_shape;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [ANGLE_WIDTH-1:0] i_angle = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [RESULT_WIDTH-1:0] o_cosine, o_sine;
    logic o_saturated;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [GAIN_WIDTH-1:0] i_cfg_data = '0;

    quartic_cos_sin_shaper uut (.*);

    // Local copy of the gain registers.
    logic signed [15:0] quad_gain_q = 16'sd4096;
    logic signed [15:0] quartic_gain_q = 16'sd4096;

    t_shape shape_queue[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  calm_phase = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic longint round_shift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint isqrt(longint x);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'sd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= x) lo = mid; else hi = mid - 1;
        end
        return lo;
    endfunction

    // Q.24 to Q4.14 with rounding and clamping.
    function automatic logic signed [RESULT_WIDTH-1:0] clamp_q14(longint v, ref logic sat);
        longint m;
        m = round_shift(v, IFRAC - (RESULT_WIDTH - 4));
        if (m > 131071) begin
            m = 131071;
            sat = 1'b1;
        end else if (m < -131072) begin
            m = -131072;
            sat = 1'b1;
        end
        return m[RESULT_WIDTH-1:0];
    endfunction

    function automatic t_shape shape_angle(logic signed [ANGLE_WIDTH-1:0] ang);
        longint u, u2, u4, ta, tb, c, d, r, sn, m, p;
        logic sat;
        t_shape res;
        u  = round_shift(longint'(ang) * 64'sd683565276, ANGLE_WIDTH - 3 + 6);
        u2 = round_shift(u * u, IFRAC);
        u4 = round_shift(u2 * u2, IFRAC);
        ta = round_shift(longint'(quad_gain_q) * u2, 13);
        p  = longint'(quartic_gain_q) * u4;
        m  = (((p < 0) ? -p : p) + 49152) / 98304;
        tb = (p < 0) ? -m : m;
        c  = (64'sd1 << IFRAC) - ta + tb;
        d  = (64'sd1 << 48) - c * c;
        r  = isqrt((d < 0) ? -d : d);
        if (ang == 0 || d == 0) sn = 0;
        else sn = ((ang < 0) != (d < 0)) ? -r : r;
        sat = 1'b0;
        res.cosine = clamp_q14(c, sat);
        res.sine = clamp_q14(sn, sat);
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Random sink stall; drop it during calm phases.
    always @(posedge i_clk) begin
        i_out_stall <= !calm_phase && ($urandom_range(99) < 19);
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shape_queue.size() == 0) begin
                report_mismatch("unexpected result", o_cosine, 0);
            end else begin
                t_shape want;
                want = shape_queue.pop_front();
                if (o_cosine !== want.cosine) report_mismatch("cosine", o_cosine, want.cosine);
                if (o_sine !== want.sine) report_mismatch("sine", o_sine, want.sine);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Watchdog: count cycles in which no request moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[quartic_cos_sin_shaper] ERROR");
            $finish;
        end
    end

    // Send one angle request, idling at random beforehand; valid stays high
    // after the accept so that back to back requests need no gap.
    task automatic send_angle(logic signed [ANGLE_WIDTH-1:0] ang);
        while (!calm_phase && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_angle <= ang;
        do @(posedge i_clk); while (o_in_stall);
        shape_queue.push_back(shape_angle(ang));
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (shape_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Drain the pipe, then write a gain register.
    task automatic write_gain(logic [1:0] idx, logic [15:0] val);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_QUAD_GAIN) quad_gain_q = val;
        else if (idx == REG_QUARTIC_GAIN) quartic_gain_q = val;
        @(posedge i_clk);
    endtask

    task automatic test_directed_angles();
        logic signed [15:0] pts[$];
        pts = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd12868, -16'sd12868,
                16'sd25736, -16'sd25736, 16'sd6434, 16'sd8192, -16'sd8192, 16'sh5555,
                16'shAAAA};
        foreach (pts[k]) send_angle(pts[k]);
    endtask

    task automatic test_gain_extremes();
        logic [15:0] g[$];
        g = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000};
        foreach (g[k]) begin
            write_gain(REG_QUAD_GAIN, g[k]);
            write_gain(REG_QUARTIC_GAIN, g[(k + 1) % 4]);
            send_angle(16'sd0);
            send_angle(16'sd32767);
            send_angle(-16'sd32768);
            send_angle(16'sd12868);
        end
        // Writes to an unused index must be ignored.
        write_gain(2'd2, 16'h1234);
        write_gain(2'd3, 16'h8001);
        write_gain(REG_QUAD_GAIN, 16'h1000);
        write_gain(REG_QUARTIC_GAIN, 16'h1000);
    endtask

    task automatic test_random_angles();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                write_gain(REG_QUAD_GAIN, 16'($urandom));
                write_gain(REG_QUARTIC_GAIN, 16'($urandom));
            end
            calm_phase = (phase == 2);
            repeat (250) send_angle(ANGLE_WIDTH'($urandom));
        end
        calm_phase = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_angles();
        test_gain_extremes();
        test_random_angles();
        drain_pipe();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (error_count == 0 && shape_queue.size() == 0)
            $display("[quartic_cos_sin_shaper] OK");
        else
            $display("[quartic_cos_sin_shaper] ERROR");
        $finish;
    end

endmodule

// ----- quartic_cos_sin_shaper.f -----
sv/qcs_pkg.sv
sv/qcs_poly.sv
sv/qcs_cell.sv
sv/quartic_cos_sin_shaper.sv
tb/quartic_cos_sin_shaper_tb.sv
